// ----- design/sfsd_pkg.sv -----
// Shared types and constants for the screen frame stream deframer.
package sfsd_pkg;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BANNER = 2'd1,
      KIND_BODY   = 2'd2,
      KIND_EMPTY  = 2'd3
   } kind_type;

   // Banner byte positions
   localparam logic [7:0] POS_VERSION    = 8'd0;
   localparam logic [7:0] POS_LENGTH     = 8'd1;
   localparam logic [7:0] POS_WORDS      = 8'd2;
   localparam logic [7:0] POS_ORIENT     = 8'd22;
   localparam logic [7:0] POS_QUIRKS     = 8'd23;
   localparam logic [7:0] MIN_BANNER_LEN = 8'd2;

   // Banner word slots
   localparam int WORD_COUNT = 5;
   localparam logic [2:0] WORD_PID    = 3'd0;
   localparam logic [2:0] WORD_REAL_W = 3'd1;
   localparam logic [2:0] WORD_REAL_H = 3'd2;
   localparam logic [2:0] WORD_VIRT_W = 3'd3;
   localparam logic [2:0] WORD_VIRT_H = 3'd4;

   // JPEG start-of-image marker and orientation step
   localparam logic [7:0]  SOI_BYTE0   = 8'hFF;
   localparam logic [7:0]  SOI_BYTE1   = 8'hD8;
   localparam logic [14:0] ORIENT_STEP = 15'd90;

   // Body byte position tracking
   localparam logic [1:0] BODY_FIRST  = 2'd0;
   localparam logic [1:0] BODY_SECOND = 2'd1;
   localparam logic [1:0] BODY_AFTER  = 2'd2;

   // One result
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body_byte;
      logic        frame_last;
      logic        not_jpeg;
      logic [7:0]  version;
      logic [31:0] pid;
      logic [31:0] real_width;
      logic [31:0] real_height;
      logic [31:0] virtual_width;
      logic [31:0] virtual_height;
      logic [14:0] orientation_deg;
      logic [7:0]  quirks;
   } rsp_type;

endpackage

// ----- design/screen_frame_stream_deframer.sv -----
// Top level of the screen frame stream deframer: banner parser and frame splitter.
//
// Takes one stream byte per request and returns exactly one result per byte, at one
// byte per clock cycle unless a full output stage holds req_ready low. Each request is
// resolved in the cycle it is taken, by counter updates and a byte insert into the
// banner or length registers; the result lands in a two-entry output stage (output
// register plus skid register), so req_ready stays high while one result waits and
// drops only when both entries hold. The banner is parsed once after reset; every
// later byte belongs to a frame of HEADER_BYTES little-endian length bytes and that
// many body bytes. Banner fields are reported on every result as held after that
// byte.
module screen_frame_stream_deframer #(
   parameter int HEADER_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_frame_last,
   output logic        rsp_not_jpeg,
   output logic [7:0]  rsp_version,
   output logic [31:0] rsp_pid,
   output logic [31:0] rsp_real_width,
   output logic [31:0] rsp_real_height,
   output logic [31:0] rsp_virtual_width,
   output logic [31:0] rsp_virtual_height,
   output logic [14:0] rsp_orientation_deg,
   output logic [7:0]  rsp_quirks
);

   localparam int HdrW = $clog2(HEADER_BYTES + 1);
   localparam logic [HdrW-1:0] HdrLen = HdrW'(HEADER_BYTES);

   // Parser state
   logic [7:0]      banner_count_ff, banner_count_in;
   logic [7:0]      banner_len_ff, banner_len_in;
   logic [31:0]     word_ff [sfsd_pkg::WORD_COUNT];
   logic [31:0]     word_in [sfsd_pkg::WORD_COUNT];
   logic [7:0]      version_ff, version_in;
   logic [14:0]     orient_ff, orient_in;
   logic [7:0]      quirks_ff, quirks_in;
   logic [HdrW-1:0] header_count_ff, header_count_in;
   logic [31:0]     remaining_ff, remaining_in;
   logic [1:0]      body_index_ff, body_index_in;
   logic            bad_start_ff, bad_start_in;

   // Output stage
   logic                 out_valid_ff, skid_valid_ff;
   sfsd_pkg::rsp_type    out_ff, skid_ff, result;

   logic       take, pop;
   logic [7:0] pos_off;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign pos_off   = banner_count_ff - sfsd_pkg::POS_WORDS;

   // Next state and result for the byte at the input
   always_comb begin
      banner_count_in = banner_count_ff;
      banner_len_in   = banner_len_ff;
      word_in         = word_ff;
      version_in      = version_ff;
      orient_in       = orient_ff;
      quirks_in       = quirks_ff;
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      body_index_in   = body_index_ff;
      bad_start_in    = bad_start_ff;
      result          = '0;
      result.kind     = sfsd_pkg::KIND_HEADER;

      if (banner_count_ff < banner_len_ff) begin
         // Banner byte
         banner_count_in = banner_count_ff + 8'd1;
         if (banner_count_ff == sfsd_pkg::POS_VERSION) begin
            version_in = req_stream_byte;
         end else if (banner_count_ff == sfsd_pkg::POS_LENGTH) begin
            banner_len_in = (req_stream_byte < sfsd_pkg::MIN_BANNER_LEN) ?
                            sfsd_pkg::MIN_BANNER_LEN : req_stream_byte;
         end else if (banner_count_ff < sfsd_pkg::POS_ORIENT) begin
            for (int i = 0; i < sfsd_pkg::WORD_COUNT; i++) begin
               if (pos_off[4:2] == 3'(i)) begin
                  word_in[i] = word_ff[i] | (32'(req_stream_byte) << {pos_off[1:0], 3'b000});
               end
            end
         end else if (banner_count_ff == sfsd_pkg::POS_ORIENT) begin
            orient_in = 15'(req_stream_byte) * sfsd_pkg::ORIENT_STEP;
         end else if (banner_count_ff == sfsd_pkg::POS_QUIRKS) begin
            quirks_in = req_stream_byte;
         end
         if (banner_count_in == banner_len_in) begin
            result.kind = sfsd_pkg::KIND_BANNER;
         end
      end else if (header_count_ff < HdrLen) begin
         // Frame length byte, little endian
         remaining_in    = remaining_ff |
                           (32'(req_stream_byte) << {header_count_ff, 3'b000});
         header_count_in = header_count_ff + HdrW'(1);
         if (header_count_in == HdrLen && remaining_in == 32'd0) begin
            result.kind       = sfsd_pkg::KIND_EMPTY;
            result.frame_last = 1'b1;
            result.not_jpeg   = 1'b1;
            header_count_in   = '0;
         end
      end else begin
         // Body byte
         result.kind      = sfsd_pkg::KIND_BODY;
         result.body_byte = req_stream_byte;
         if (body_index_ff == sfsd_pkg::BODY_FIRST) begin
            bad_start_in  = (req_stream_byte != sfsd_pkg::SOI_BYTE0);
            body_index_in = sfsd_pkg::BODY_SECOND;
         end else if (body_index_ff == sfsd_pkg::BODY_SECOND) begin
            bad_start_in  = bad_start_ff | (req_stream_byte != sfsd_pkg::SOI_BYTE1);
            body_index_in = sfsd_pkg::BODY_AFTER;
         end
         remaining_in = remaining_ff - 32'd1;
         if (remaining_in == 32'd0) begin
            result.frame_last = 1'b1;
            result.not_jpeg   = bad_start_in || (body_index_in < sfsd_pkg::BODY_AFTER);
            header_count_in   = '0;
            body_index_in     = sfsd_pkg::BODY_FIRST;
            bad_start_in      = 1'b0;
         end
      end

      result.version         = version_in;
      result.pid             = word_in[sfsd_pkg::WORD_PID];
      result.real_width      = word_in[sfsd_pkg::WORD_REAL_W];
      result.real_height     = word_in[sfsd_pkg::WORD_REAL_H];
      result.virtual_width   = word_in[sfsd_pkg::WORD_VIRT_W];
      result.virtual_height  = word_in[sfsd_pkg::WORD_VIRT_H];
      result.orientation_deg = orient_in;
      result.quirks          = quirks_in;
   end

   // Parser state registers, advanced on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         banner_count_ff <= '0;
         banner_len_ff   <= sfsd_pkg::MIN_BANNER_LEN;
         for (int i = 0; i < sfsd_pkg::WORD_COUNT; i++) begin
            word_ff[i] <= '0;
         end
         version_ff      <= '0;
         orient_ff       <= '0;
         quirks_ff       <= '0;
         header_count_ff <= '0;
         remaining_ff    <= '0;
         body_index_ff   <= sfsd_pkg::BODY_FIRST;
         bad_start_ff    <= 1'b0;
      end else if (take) begin
         banner_count_ff <= banner_count_in;
         banner_len_ff   <= banner_len_in;
         word_ff         <= word_in;
         version_ff      <= version_in;
         orient_ff       <= orient_in;
         quirks_ff       <= quirks_in;
         header_count_ff <= header_count_in;
         remaining_ff    <= remaining_in;
         body_index_ff   <= body_index_in;
         bad_start_ff    <= bad_start_in;
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (take) begin
         skid_ff <= result;
      end
   end

   // Result ports
   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_ff.kind;
   assign rsp_body_byte       = out_ff.body_byte;
   assign rsp_frame_last      = out_ff.frame_last;
   assign rsp_not_jpeg        = out_ff.not_jpeg;
   assign rsp_version         = out_ff.version;
   assign rsp_pid             = out_ff.pid;
   assign rsp_real_width      = out_ff.real_width;
   assign rsp_real_height     = out_ff.real_height;
   assign rsp_virtual_width   = out_ff.virtual_width;
   assign rsp_virtual_height  = out_ff.virtual_height;
   assign rsp_orientation_deg = out_ff.orientation_deg;
   assign rsp_quirks          = out_ff.quirks;

endmodule

// ----- design/sfsd_checker.sv -----
// Port-level assertions for the screen frame stream deframer, bound to the top level.
module sfsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_stream_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_body_byte,
   input logic        rsp_frame_last,
   input logic        rsp_not_jpeg,
   input logic [7:0]  rsp_version,
   input logic [31:0] rsp_pid,
   input logic [31:0] rsp_real_width,
   input logic [31:0] rsp_real_height,
   input logic [31:0] rsp_virtual_width,
   input logic [31:0] rsp_virtual_height,
   input logic [14:0] rsp_orientation_deg,
   input logic [7:0]  rsp_quirks
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_body_byte) && $stable(rsp_frame_last) && $stable(rsp_pid))
      else $error("stalled result changed");

   // Frame end only on a body byte or an empty frame
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |->
      rsp_kind == sfsd_pkg::KIND_BODY || rsp_kind == sfsd_pkg::KIND_EMPTY)
      else $error("frame_last on a header or banner result");

   // JPEG check is reported only at frame end
   a_notj_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_jpeg |-> rsp_frame_last)
      else $error("not_jpeg without frame_last");

   // Empty frame closes the frame and fails the marker check
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sfsd_pkg::KIND_EMPTY |-> rsp_frame_last && rsp_not_jpeg)
      else $error("empty frame not flagged");

   // Body byte is zero outside the body
   a_body_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != sfsd_pkg::KIND_BODY |-> rsp_body_byte == 8'd0)
      else $error("body byte set outside body");

endmodule

bind screen_frame_stream_deframer sfsd_checker u_sfsd_checker (.*);

// ----- tb/screen_frame_stream_deframer_tb.sv -----
// Self-checking testbench for the screen frame stream deframer: banner then framed bodies.
`timescale 1ns / 1ps

module screen_frame_stream_deframer_tb;

   localparam int HEADER_LEN = 4;
   localparam int EXTRA_ITEMS = 820;

   // Body start styles for generated frames
   localparam int START_JPEG       = 0;
   localparam int START_BAD_FIRST  = 1;
   localparam int START_BAD_SECOND = 2;
   localparam int START_RANDOM     = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_body_byte;
   logic        rsp_frame_last;
   logic        rsp_not_jpeg;
   logic [7:0]  rsp_version;
   logic [31:0] rsp_pid;
   logic [31:0] rsp_real_width;
   logic [31:0] rsp_real_height;
   logic [31:0] rsp_virtual_width;
   logic [31:0] rsp_virtual_height;
   logic [14:0] rsp_orientation_deg;
   logic [7:0]  rsp_quirks;

   screen_frame_stream_deframer #(.HEADER_BYTES(HEADER_LEN)) dut (.*);

   always #5 clock = ~clock;

   // Pending stream bytes and expected results
   logic [7:0]        stream_q[$];
   sfsd_pkg::rsp_type expected_q[$];
   int                mismatches = 0;

   // Deframer state as the predictor tracks it
   logic [7:0]  ban_count = 8'd0;
   logic [7:0]  ban_len = sfsd_pkg::MIN_BANNER_LEN;
   logic [31:0] ban_words[sfsd_pkg::WORD_COUNT] = '{default: 32'd0};
   logic [7:0]  ban_version = 8'd0;
   logic [14:0] ban_orient = 15'd0;
   logic [7:0]  ban_quirks = 8'd0;
   int          len_count = 0;
   logic [31:0] frame_left = 32'd0;
   logic [1:0]  body_pos = sfsd_pkg::BODY_FIRST;
   logic        bad_soi = 1'b0;

   // Work out the result of one accepted stream byte
   task automatic predict_byte(input logic [7:0] b);
      sfsd_pkg::rsp_type r;
      logic [7:0]        rel;
      r = '0;
      r.kind = sfsd_pkg::KIND_HEADER;
      if (ban_count < ban_len) begin
         if (ban_count == sfsd_pkg::POS_VERSION) begin
            ban_version = b;
         end else if (ban_count == sfsd_pkg::POS_LENGTH) begin
            ban_len = (b < sfsd_pkg::MIN_BANNER_LEN) ? sfsd_pkg::MIN_BANNER_LEN : b;
         end else if (ban_count < sfsd_pkg::POS_ORIENT) begin
            rel = ban_count - sfsd_pkg::POS_WORDS;
            ban_words[rel >> 2] = ban_words[rel >> 2] | (32'(b) << (8 * rel[1:0]));
         end else if (ban_count == sfsd_pkg::POS_ORIENT) begin
            ban_orient = 15'(b) * sfsd_pkg::ORIENT_STEP;
         end else if (ban_count == sfsd_pkg::POS_QUIRKS) begin
            ban_quirks = b;
         end
         ban_count = ban_count + 8'd1;
         if (ban_count == ban_len) r.kind = sfsd_pkg::KIND_BANNER;
      end else if (len_count < HEADER_LEN) begin
         frame_left = frame_left | (32'(b) << (8 * len_count));
         len_count++;
         // zero-length frame closes on its last length byte
         if (len_count == HEADER_LEN && frame_left == 32'd0) begin
            r.kind = sfsd_pkg::KIND_EMPTY;
            r.frame_last = 1'b1;
            r.not_jpeg = 1'b1;
            len_count = 0;
         end
      end else begin
         r.kind = sfsd_pkg::KIND_BODY;
         r.body_byte = b;
         if (body_pos == sfsd_pkg::BODY_FIRST) begin
            bad_soi = (b != sfsd_pkg::SOI_BYTE0);
            body_pos = sfsd_pkg::BODY_SECOND;
         end else if (body_pos == sfsd_pkg::BODY_SECOND) begin
            bad_soi = bad_soi | (b != sfsd_pkg::SOI_BYTE1);
            body_pos = sfsd_pkg::BODY_AFTER;
         end
         frame_left = frame_left - 32'd1;
         if (frame_left == 32'd0) begin
            r.frame_last = 1'b1;
            r.not_jpeg = bad_soi || (body_pos != sfsd_pkg::BODY_AFTER);
            len_count = 0;
            body_pos = sfsd_pkg::BODY_FIRST;
            bad_soi = 1'b0;
         end
      end
      r.version = ban_version;
      r.pid = ban_words[sfsd_pkg::WORD_PID];
      r.real_width = ban_words[sfsd_pkg::WORD_REAL_W];
      r.real_height = ban_words[sfsd_pkg::WORD_REAL_H];
      r.virtual_width = ban_words[sfsd_pkg::WORD_VIRT_W];
      r.virtual_height = ban_words[sfsd_pkg::WORD_VIRT_H];
      r.orientation_deg = ban_orient;
      r.quirks = ban_quirks;
      expected_q.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // Stream building helpers
   task automatic push_len(input logic [31:0] n);
      for (int i = 0; i < HEADER_LEN; i++) stream_q.push_back(n[8*i +: 8]);
   endtask

   task automatic push_body(input int count, input int style);
      logic [7:0] v;
      for (int i = 0; i < count; i++) begin
         v = 8'($urandom);
         if (i == 0) begin
            if (style == START_JPEG || style == START_BAD_SECOND) v = sfsd_pkg::SOI_BYTE0;
            else if (style == START_BAD_FIRST) v = 8'($urandom_range(0, 254));
         end else if (i == 1) begin
            if (style == START_JPEG) begin
               v = sfsd_pkg::SOI_BYTE1;
            end else if (style == START_BAD_SECOND) begin
               v = 8'($urandom_range(0, 254));
               if (v >= sfsd_pkg::SOI_BYTE1) v = v + 8'd1;
            end
         end
         stream_q.push_back(v);
      end
   endtask

   task automatic push_frame(input int count, input int style);
      push_len(32'(count));
      push_body(count, style);
   endtask

   // Driver: bursts of requests separated by random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stream_q.size() > 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= stream_q.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: ready always, half the time or a quarter of the time, by a random mode
   int stall_mode = 0;
   int stall_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_cycle % 50 == 0) stall_mode = $urandom_range(0, 2);
         stall_cycle++;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      sfsd_pkg::rsp_type r;
      if (!reset) begin
         if (req_valid && req_ready) predict_byte(req_stream_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no request pending: kind 0x%0h", rsp_kind);
               mismatches++;
            end else begin
               r = expected_q.pop_front();
               check_field("kind", 32'(r.kind), 32'(rsp_kind));
               check_field("body_byte", 32'(r.body_byte), 32'(rsp_body_byte));
               check_field("frame_last", 32'(r.frame_last), 32'(rsp_frame_last));
               check_field("not_jpeg", 32'(r.not_jpeg), 32'(rsp_not_jpeg));
               check_field("version", 32'(r.version), 32'(rsp_version));
               check_field("pid", r.pid, rsp_pid);
               check_field("real_width", r.real_width, rsp_real_width);
               check_field("real_height", r.real_height, rsp_real_height);
               check_field("virtual_width", r.virtual_width, rsp_virtual_width);
               check_field("virtual_height", r.virtual_height, rsp_virtual_height);
               check_field("orientation_deg", 32'(r.orientation_deg),
                           32'(rsp_orientation_deg));
               check_field("quirks", 32'(r.quirks), 32'(rsp_quirks));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int banner_class;
      int len_byte;
      int banner_total;
      int target;
      int pick;
      int n;

      // Banner: short, partial, exact or padded length, chosen per run
      banner_class = $urandom_range(0, 3);
      case (banner_class)
         0: len_byte = $urandom_range(0, 1);
         1: len_byte = $urandom_range(2, 23);
         2: len_byte = 24;
         default: len_byte = $urandom_range(25, 40);
      endcase
      banner_total = (len_byte < sfsd_pkg::MIN_BANNER_LEN) ? sfsd_pkg::MIN_BANNER_LEN : len_byte;
      stream_q.push_back(8'($urandom));
      stream_q.push_back(8'(len_byte));
      for (int i = 2; i < banner_total; i++) stream_q.push_back(8'($urandom));

      // Directed frames: empty, one byte, good and broken markers, a second empty
      push_frame(0, START_RANDOM);
      push_frame(1, START_JPEG);
      push_frame(2, START_JPEG);
      push_frame(2, START_BAD_SECOND);
      push_frame(0, START_RANDOM);
      push_frame(3, START_BAD_FIRST);
      push_frame(1, START_BAD_FIRST);

      // Random frames, mostly well-formed image bodies
      target = stream_q.size() + EXTRA_ITEMS;
      while (stream_q.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_frame(0, START_RANDOM);
         end else if (pick < 16) begin
            push_frame(1, START_RANDOM);
         end else if (pick < 24) begin
            push_frame($urandom_range(25, 200), START_RANDOM);
         end else if (pick < 36) begin
            n = $urandom_range(2, 24);
            push_frame(n, ($urandom_range(0, 1) == 0) ? START_BAD_FIRST : START_BAD_SECOND);
         end else begin
            push_frame($urandom_range(2, 24), START_JPEG);
         end
      end

      // Full-scale length left unfinished at the end of the stream
      push_len(32'hFFFF_FFFF);
      push_body(20, START_JPEG);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (stream_q.size() > 0 || req_valid) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule
